// File: hdl/segment_digit_classifier_assert.svh
// Assertion macros for the segment digit classifier.
`ifndef SEGMENT_DIGIT_CLASSIFIER_ASSERT_SVH
`define SEGMENT_DIGIT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SDC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdc assertion failed");

// Next-cycle implication, disabled while in reset.
`define SDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdc assertion failed");

`endif

// File: hdl/sdc_pkg.sv
// Shared constants, types and helpers for the segment digit classifier.
package sdc_pkg;

  localparam int SIDE_BITS_DEF  = 10;
  localparam int SPOTS_KEPT_DEF = 3;

  localparam int PIX_W   = 8;
  localparam int HIT_W   = 4;
  localparam int DIGIT_W = 4;

  localparam logic [PIX_W-1:0] STEP_LIMIT = 8'd200;
  localparam logic [HIT_W-1:0] HITS_MAX   = 4'd15;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 4'd0;

  typedef struct packed {
    logic [HIT_W-1:0] upper;
    logic [HIT_W-1:0] lower;
    logic [HIT_W-1:0] center;
  } hits_t;

  function automatic logic strong_step(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d > STEP_LIMIT;
  endfunction

  function automatic logic [HIT_W-1:0] bump_hits(input logic [HIT_W-1:0] hits, input logic hit);
    return (hit && hits != HITS_MAX) ? hits + 1'b1 : hits;
  endfunction

endpackage

// File: hdl/sdc_scan.sv
// Raster scan state: positions, neighbor pixels, transition counts and spots.
module sdc_scan import sdc_pkg::*; #(
  parameter int SIDE_BITS  = SIDE_BITS_DEF,
  parameter int SPOTS_KEPT = SPOTS_KEPT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [PIX_W-1:0]     pixel,
  input  logic [SIDE_BITS-1:0] img_height,
  input  logic [SIDE_BITS-1:0] img_width,
  input  logic                 last_pixel,
  output hits_t                hits_nxt,
  output logic [SIDE_BITS-1:0] up_spots_nxt [SPOTS_KEPT],
  output logic [SIDE_BITS-1:0] lo_spots_nxt [SPOTS_KEPT]
);

  // x/3 as x*ceil(2^K/3) >> K, exact for x below 2^(SIDE_BITS+1)
  localparam int DIV_K = SIDE_BITS + 3;
  localparam int PROD_W = SIDE_BITS + 1 + DIV_K;
  localparam logic [DIV_K-1:0] DIV_M = DIV_K'(((1 << DIV_K) + 2) / 3);

  logic [SIDE_BITS-1:0] row_r, row_nxt;
  logic [SIDE_BITS-1:0] col_r, col_nxt;
  logic [PIX_W-1:0]     left_r, left_nxt;
  logic [PIX_W-1:0]     above_r, above_nxt;
  hits_t                hits_r, hits_next_scan;
  logic [SIDE_BITS-1:0] up_spots_r [SPOTS_KEPT];
  logic [SIDE_BITS-1:0] lo_spots_r [SPOTS_KEPT];

  logic [PROD_W-1:0]    prod_third, prod_two_third;
  logic [SIDE_BITS-1:0] third, two_third, half, pos;
  logic                 row_hit_ok, up_hit, lo_hit, at_center, ctr_hit, col_end;

  assign prod_third     = PROD_W'({1'b0, img_height}) * PROD_W'(DIV_M);
  assign prod_two_third = PROD_W'({img_height, 1'b0}) * PROD_W'(DIV_M);
  assign third          = prod_third[DIV_K +: SIDE_BITS];
  assign two_third      = prod_two_third[DIV_K +: SIDE_BITS];
  assign half           = img_width >> 1;
  assign pos            = col_r - 1'b1;

  assign row_hit_ok = (col_r != '0) && strong_step(left_r, pixel);
  assign up_hit     = row_hit_ok && (row_r == third);
  assign lo_hit     = row_hit_ok && (row_r == two_third);
  assign at_center  = (col_r == half);
  assign ctr_hit    = at_center && (row_r != '0) && (row_r < img_height)
                      && strong_step(above_r, pixel);
  assign col_end    = ({1'b0, col_r} + 1'b1) >= {1'b0, img_width};

  always_comb begin
    hits_nxt.upper  = bump_hits(hits_r.upper, up_hit);
    hits_nxt.lower  = bump_hits(hits_r.lower, lo_hit);
    hits_nxt.center = bump_hits(hits_r.center, ctr_hit);
    for (int i = 0; i < SPOTS_KEPT; i++) begin
      up_spots_nxt[i] = (up_hit && hits_r.upper == HIT_W'(i)) ? pos : up_spots_r[i];
      lo_spots_nxt[i] = (lo_hit && hits_r.lower == HIT_W'(i)) ? pos : lo_spots_r[i];
    end
  end

  always_comb begin
    if (last_pixel) begin
      row_nxt        = '0;
      col_nxt        = '0;
      left_nxt       = '0;
      above_nxt      = '0;
      hits_next_scan = '0;
    end else begin
      row_nxt        = col_end ? row_r + 1'b1 : row_r;
      col_nxt        = col_end ? '0 : col_r + 1'b1;
      left_nxt       = pixel;
      above_nxt      = at_center ? pixel : above_r;
      hits_next_scan = hits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      left_r  <= '0;
      above_r <= '0;
      hits_r  <= '0;
    end else if (go) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      left_r  <= left_nxt;
      above_r <= above_nxt;
      hits_r  <= hits_next_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      up_spots_r <= up_spots_nxt;
      lo_spots_r <= lo_spots_nxt;
    end
  end

endmodule

// File: hdl/sdc_classify.sv
// Decision logic: aspect-ratio shortcuts and transition pattern match.
module sdc_classify import sdc_pkg::*; #(
  parameter int SIDE_BITS  = SIDE_BITS_DEF,
  parameter int SPOTS_KEPT = SPOTS_KEPT_DEF
) (
  input  hits_t                hits,
  input  logic [SIDE_BITS-1:0] img_height,
  input  logic [SIDE_BITS-1:0] img_width,
  input  logic [SIDE_BITS-1:0] up_spots [SPOTS_KEPT],
  input  logic [SIDE_BITS-1:0] lo_spots [SPOTS_KEPT],
  output logic [DIGIT_W-1:0]   digit,
  output logic                 status
);

  localparam int EXT_W = SIDE_BITS + 4;

  logic [EXT_W-1:0]     h_ext, w3, w10;
  logic [SIDE_BITS-1:0] half;
  logic                 u0_gt, u1_lt, u2_gt, l0_gt, l1_lt, l2_gt;
  logic                 tall_thin, bad_shape;

  assign h_ext = EXT_W'(img_height);
  assign w3    = EXT_W'({img_width, 1'b0}) + EXT_W'(img_width);
  assign w10   = EXT_W'({img_width, 3'b000}) + EXT_W'({img_width, 1'b0});
  assign half  = img_width >> 1;

  assign bad_shape = (img_height == '0) || (img_width == '0) || (img_height < img_width);
  assign tall_thin = (h_ext > w3) && (h_ext < w10);

  assign u0_gt = up_spots[0] > half;
  assign u1_lt = up_spots[1] < half;
  assign u2_gt = up_spots[2] > half;
  assign l0_gt = lo_spots[0] > half;
  assign l1_lt = lo_spots[1] < half;
  assign l2_gt = lo_spots[2] > half;

  always_comb begin
    digit = DIGIT_NONE;
    if (bad_shape) begin
      digit = DIGIT_NONE;
    end else if (tall_thin) begin
      digit = 4'd1;
    end else if (hits.upper == 4'd2 && hits.lower == 4'd2 && hits.center == 4'd2) begin
      digit = 4'd7;
    end else if (hits.upper == 4'd4 && hits.lower == 4'd2 && hits.center == 4'd2) begin
      digit = 4'd4;
    end else if (hits.upper == 4'd2 && hits.lower == 4'd2 && hits.center == 4'd6
                 && ((u0_gt && l1_lt) || (u0_gt && l0_gt) || (u1_lt && l0_gt))) begin
      if (u0_gt && l1_lt) begin
        digit = 4'd2;
      end else if (u0_gt && l0_gt) begin
        digit = 4'd3;
      end else begin
        digit = 4'd5;
      end
    end else if (hits.upper == 4'd2 && hits.lower == 4'd4 && hits.center == 4'd6
                 && u1_lt && l1_lt && l2_gt) begin
      digit = 4'd6;
    end else if (hits.upper == 4'd4 && hits.lower == 4'd2 && hits.center == 4'd6
                 && u1_lt && u2_gt && l0_gt) begin
      digit = 4'd9;
    end else if (hits.upper == 4'd4 && hits.lower == 4'd4 && hits.center == 4'd6) begin
      digit = 4'd8;
    end
  end

  assign status = (digit == DIGIT_NONE) ? STATUS_REJECT : STATUS_OK;

endmodule

// File: hdl/segment_digit_classifier.sv
// An accepted pixel is registered in the input stage and scanned from there; the
// result of a last pixel is then held in the result register and shown until taken.
// Throughput: one pixel per cycle; a last pixel waits only while the result register
// is still full and not being taken.
// Reset (rst_n low, synchronous): scan position, neighbor pixels and counts clear,
// both stages empty; stored spot positions are not cleared.
module segment_digit_classifier import sdc_pkg::*; #(
  parameter int SIDE_BITS  = SIDE_BITS_DEF,
  parameter int SPOTS_KEPT = SPOTS_KEPT_DEF,
  localparam int IN_BITS   = PIX_W + 2 * SIDE_BITS,
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,  // pixel, img_height, img_width
  input  logic                 in_tlast,  // last_pixel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata, // digit
  output logic                 out_tuser  // status
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0]     s1_pixel_r;
  logic [SIDE_BITS-1:0] s1_height_r, s1_width_r;
  logic                 s1_last_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0]   out_digit_r;
  logic                 out_status_r;

  logic in_fire, out_free, s1_go;

  hits_t                hits_nxt;
  logic [SIDE_BITS-1:0] up_spots_nxt [SPOTS_KEPT];
  logic [SIDE_BITS-1:0] lo_spots_nxt [SPOTS_KEPT];
  logic [DIGIT_W-1:0]   digit_nxt;
  logic                 status_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_go && s1_last_r) ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel_r  <= in_tdata[PIX_W-1:0];
      s1_height_r <= in_tdata[PIX_W +: SIDE_BITS];
      s1_width_r  <= in_tdata[PIX_W + SIDE_BITS +: SIDE_BITS];
      s1_last_r   <= in_tlast;
    end
    if (s1_go && s1_last_r) begin
      out_digit_r  <= digit_nxt;
      out_status_r <= status_nxt;
    end
  end

  sdc_scan #(
    .SIDE_BITS  (SIDE_BITS),
    .SPOTS_KEPT (SPOTS_KEPT)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (s1_go),
    .pixel        (s1_pixel_r),
    .img_height   (s1_height_r),
    .img_width    (s1_width_r),
    .last_pixel   (s1_last_r),
    .hits_nxt     (hits_nxt),
    .up_spots_nxt (up_spots_nxt),
    .lo_spots_nxt (lo_spots_nxt)
  );

  sdc_classify #(
    .SIDE_BITS  (SIDE_BITS),
    .SPOTS_KEPT (SPOTS_KEPT)
  ) u_classify (
    .hits       (hits_nxt),
    .img_height (s1_height_r),
    .img_width  (s1_width_r),
    .up_spots   (up_spots_nxt),
    .lo_spots   (lo_spots_nxt),
    .digit      (digit_nxt),
    .status     (status_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_digit_r};
  assign out_tuser  = out_status_r;

`include "segment_digit_classifier_assert.svh"

  `SDC_ASSERT_IMPL(a_status_matches_digit, out_valid_r,
                   (out_status_r == STATUS_REJECT) == (out_digit_r == DIGIT_NONE))
  `SDC_ASSERT_NEXT(a_last_makes_result, s1_go && s1_last_r, out_valid_r)
  `SDC_ASSERT_IMPL(a_last_stalls_input, s1_valid_r && s1_last_r && out_valid_r && !out_tready,
                   !in_tready)

endmodule
